// ===== rtl/xtea_block_cipher_core_assert.svh =====
// assertion macros for the xtea block cipher core
// no dependencies; included by modules that carry concurrent checks
`ifndef XTEA_BLOCK_CIPHER_CORE_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define XTEA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xtea check failed");

// next-cycle implication, disabled during reset
`define XTEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xtea check failed");

`endif

// ===== rtl/xtea_pkg.sv =====
// shared types, constants and the round mixing function for the xtea core
// no dependencies
package xtea_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ROUND_W  = 8;
   localparam int unsigned KEY_N    = 4;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;
   localparam int unsigned SHIFT_L = 4;
   localparam int unsigned SHIFT_R = 5;
   localparam int unsigned KSEL_HI = 11;

   // register indices of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS = 3'd4;

   localparam logic [ROUND_W-1:0] ROUNDS_RESET = 8'd32;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [KEY_N-1:0] key_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } xtea_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic phase;
   } xtea_cmd_type;

   // ((x << 4) ^ (x >> 5)) + x
   function automatic word_type xtea_mix(input word_type x);
      xtea_mix = ((x << SHIFT_L) ^ (x >> SHIFT_R)) + x;
   endfunction

endpackage

// ===== rtl/xtea_dp.sv =====
// xtea datapath: block halves, running sum, one half-round per step
// depends on xtea_pkg
module xtea_dp (
   input  logic                 clock,
   input  xtea_pkg::xtea_cmd_type cmd,
   input  logic                 req_mode,
   input  xtea_pkg::word_type   req_block_word0,
   input  xtea_pkg::word_type   req_block_word1,
   input  xtea_pkg::key_type    key,
   input  logic [7:0]           round_count,
   output xtea_pkg::word_type   out_word0,
   output xtea_pkg::word_type   out_word1
);
   import xtea_pkg::*;

   word_type a_ff, a_in;
   word_type b_ff, b_in;
   word_type sum_ff, sum_in;
   logic     mode_ff, mode_in;

   logic [WORD_W+ROUND_W-1:0] start_sum;
   logic                      upd_b;
   logic [1:0]                key_idx;
   word_type                  mix_src;
   word_type                  target;
   word_type                  func;

   // decryption starts from delta times the round count
   assign start_sum = (WORD_W+ROUND_W)'(XTEA_DELTA) * (WORD_W+ROUND_W)'(round_count);

   // half-round select: which half is updated and which key word is used
   assign upd_b   = mode_ff ^ cmd.phase;
   assign key_idx = upd_b ? sum_ff[KSEL_HI+1:KSEL_HI] : sum_ff[1:0];
   assign mix_src = upd_b ? a_ff : b_ff;
   assign target  = upd_b ? b_ff : a_ff;
   assign func    = xtea_mix(mix_src) ^ (sum_ff + key[key_idx]);

   // next values
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      sum_in  = sum_ff;
      mode_in = mode_ff;
      if (cmd.load) begin
         a_in    = req_block_word0;
         b_in    = req_block_word1;
         mode_in = req_mode;
         sum_in  = req_mode ? start_sum[WORD_W-1:0] : '0;
      end else if (cmd.step) begin
         if (upd_b) begin
            b_in = mode_ff ? (target - func) : (target + func);
         end else begin
            a_in = mode_ff ? (target - func) : (target + func);
         end
         if (!cmd.phase) begin
            sum_in = mode_ff ? (sum_ff - XTEA_DELTA) : (sum_ff + XTEA_DELTA);
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      sum_ff  <= sum_in;
      mode_ff <= mode_in;
   end

   assign out_word0 = a_ff;
   assign out_word1 = b_ff;

endmodule

// ===== rtl/xtea_ctrl.sv =====
// xtea controller: request acceptance, round counting and result strobe
// depends on xtea_pkg and xtea_block_cipher_core_assert.svh
module xtea_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [7:0]             round_count,
   output logic                   busy,
   output logic                   rsp_valid,
   output xtea_pkg::xtea_cmd_type cmd
);
   import xtea_pkg::*;

   `include "xtea_block_cipher_core_assert.svh"

   xtea_state_type      state_ff, state_in;
   logic [ROUND_W-1:0]  left_ff, left_in;
   logic                phase_ff, phase_in;
   logic                accept;
   logic                last_step;

   assign accept    = start && !busy;
   assign last_step = (state_ff == ST_RUN) && phase_ff && (left_ff == ROUND_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (accept) begin
               state_in = (round_count == '0) ? ST_DONE : ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // round counter and phase
   always_comb begin
      left_in  = left_ff;
      phase_in = phase_ff;
      if (accept) begin
         left_in  = round_count;
         phase_in = 1'b0;
      end else if (state_ff == ST_RUN) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            left_in = left_ff - ROUND_W'(1);
         end
      end
   end

   // outputs
   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_RUN: begin
            busy      = 1'b1;
            cmd.step  = 1'b1;
            cmd.phase = phase_ff;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         phase_ff <= phase_in;
      end
   end

   // checks
   `XTEA_ASSERT_NEXT(a_load_run, clock, reset, accept && (round_count != '0), (state_ff == ST_RUN) && (left_ff == $past(round_count)) && !phase_ff)
   `XTEA_ASSERT_NEXT(a_last_done, clock, reset, last_step, rsp_valid)
   `XTEA_ASSERT_SAME(a_run_left, clock, reset, state_ff == ST_RUN, left_ff != '0)
   `XTEA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid && !(accept && (round_count == '0)), !rsp_valid)

endmodule

// ===== rtl/xtea_block_cipher_core.sv =====
// xtea block cipher core top level: configuration registers, controller, datapath
// depends on xtea_pkg, xtea_ctrl and xtea_dp
//
// usage
//   request: a block (req_block_word0/1) and req_mode (0 encrypt, 1 decrypt) are
//   taken at a clock edge where start is high and busy is low.
//   result: rsp_out_word0/1 are shown for exactly one cycle with rsp_valid high;
//   the receiver cannot stall, so the result must be captured in that cycle.
//   configuration: csr_index selects key word 0..3 or round count (index 4);
//   csr_ready is always high, indices above 4 are ignored. write only while idle.
// timing
//   each round is two half-rounds, one per cycle, through a single adder chain
//   in the datapath. with N configured rounds the controller runs all N rounds in
//   ST_RUN, then the strobe comes from ST_DONE (straight after the accepting edge
//   for zero rounds, block unchanged). busy drops in the strobe cycle, so a new
//   request can be taken there, not while a block is in its rounds (default 32).
// reset
//   synchronous reset returns to idle, clears the key to zero and sets 32 rounds.
module xtea_block_cipher_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  xtea_pkg::word_type req_block_word0,
   input  xtea_pkg::word_type req_block_word1,
   output logic               rsp_valid,
   output xtea_pkg::word_type rsp_out_word0,
   output xtea_pkg::word_type rsp_out_word1,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  xtea_pkg::word_type csr_wdata
);
   import xtea_pkg::*;

   key_type            key_ff, key_in;
   logic [ROUND_W-1:0] rounds_ff, rounds_in;
   xtea_cmd_type       cmd;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      key_in    = key_ff;
      rounds_in = rounds_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY0:   key_in[0] = csr_wdata;
            CSR_KEY1:   key_in[1] = csr_wdata;
            CSR_KEY2:   key_in[2] = csr_wdata;
            CSR_KEY3:   key_in[3] = csr_wdata;
            CSR_ROUNDS: rounds_in = csr_wdata[ROUND_W-1:0];
            default:    rounds_in = rounds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         rounds_ff <= ROUNDS_RESET;
      end else begin
         key_ff    <= key_in;
         rounds_ff <= rounds_in;
      end
   end

   // sequencing
   xtea_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .round_count (rounds_ff),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd)
   );

   // round arithmetic
   xtea_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_block_word0 (req_block_word0),
      .req_block_word1 (req_block_word1),
      .key             (key_ff),
      .round_count     (rounds_ff),
      .out_word0       (rsp_out_word0),
      .out_word1       (rsp_out_word1)
   );

endmodule
